// ===== sv/dmtlb_pkg.sv =====
// Shared types and constants for the direct-mapped TLB translate core.
package dmtlb_pkg;

    localparam int NUM_ENTRIES_DEF = 4;

    localparam int VA_W     = 64;
    localparam int VPN_W    = 63;
    localparam int FRAME_W  = 64;
    localparam int SHIFT_W  = 6;
    localparam int COST_W   = 16;
    localparam int CNT_W    = 32;
    localparam int ENTRY_W  = FRAME_W + VPN_W + 1;   // {frame, tag, valid}

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_FIELD_W = VA_W + 1 + COST_W + 2 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ADD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_COST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_COST  = 2'd3;

    localparam logic [SHIFT_W-1:0] SHIFT_RST     = 6'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN     = 6'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX     = 6'd62;
    localparam logic [SHIFT_W-1:0] SHIFT_ILL_LO  = 6'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_ILL_HI  = 6'd63;
    localparam logic [FRAME_W-1:0] PAGE_ADD_RST  = 64'd4096;
    localparam logic [COST_W-1:0]  HIT_COST_RST  = 16'd4;
    localparam logic [COST_W-1:0]  MISS_COST_RST = 16'd30;

    // Remainder unit for a table size that is not a power of two
    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = 64 / MOD_BITS;
    localparam int MOD_CNT_W = 4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_LOOK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic mod_step;
        logic ram_rd;
        logic lookup;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
    } t_dp_stat;

endpackage

// ===== sv/dmtlb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/dmtlb_ctrl.sv =====
// Sequencing state machine: clearing pass, input/output handshakes, lookup steps.
module dmtlb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output dmtlb_pkg::t_dp_cmd   o_cmd,
    input  dmtlb_pkg::t_dp_stat  i_stat
);
    dmtlb_pkg::t_state r_state, n_state;
    logic r_m_valid, n_m_valid;
    logic out_free;

    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmtlb_pkg::S_CLEAR: if (i_stat.clr_done) n_state = dmtlb_pkg::S_IDLE;
            dmtlb_pkg::S_IDLE:  if (i_s_tvalid)      n_state = dmtlb_pkg::S_INDEX;
            dmtlb_pkg::S_INDEX: if (i_stat.mod_done) n_state = dmtlb_pkg::S_LOOK;
            dmtlb_pkg::S_LOOK:  n_state = dmtlb_pkg::S_OUT;
            dmtlb_pkg::S_OUT:   if (out_free)        n_state = dmtlb_pkg::S_IDLE;
            default:            n_state = dmtlb_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        unique case (r_state)
            dmtlb_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            dmtlb_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            dmtlb_pkg::S_INDEX: begin
                o_cmd.mod_step = !i_stat.mod_done;
                o_cmd.ram_rd   = i_stat.mod_done;
            end
            dmtlb_pkg::S_LOOK:  o_cmd.lookup   = 1'b1;
            dmtlb_pkg::S_OUT:   o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    // Output register holds a result until the downstream transfer
    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.load_out) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dmtlb_pkg::S_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;
endmodule

// ===== sv/dmtlb_dp.sv =====
// Datapath: config registers, page split, index, entry table, counters, result register.
module dmtlb_dp #(
    parameter int NUM_ENTRIES = dmtlb_pkg::NUM_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dmtlb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dmtlb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [dmtlb_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic [dmtlb_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input  dmtlb_pkg::t_dp_cmd                  i_cmd,
    output dmtlb_pkg::t_dp_stat                 o_stat
);
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam bit POW2  = ((NUM_ENTRIES & (NUM_ENTRIES - 1)) == 0);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);
    localparam int PAD_W = dmtlb_pkg::OUT_TDATA_W - dmtlb_pkg::OUT_FIELD_W;

    // Configuration registers
    logic [dmtlb_pkg::SHIFT_W-1:0] r_page_shift;
    logic [dmtlb_pkg::FRAME_W-1:0] r_page_add;
    logic [dmtlb_pkg::COST_W-1:0]  r_hit_cost;
    logic [dmtlb_pkg::COST_W-1:0]  r_miss_cost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= dmtlb_pkg::SHIFT_RST;
            r_page_add   <= dmtlb_pkg::PAGE_ADD_RST;
            r_hit_cost   <= dmtlb_pkg::HIT_COST_RST;
            r_miss_cost  <= dmtlb_pkg::MISS_COST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dmtlb_pkg::CFG_PAGE_SHIFT:
                    r_page_shift <= i_cfg_wdata[dmtlb_pkg::SHIFT_W-1:0];
                dmtlb_pkg::CFG_PAGE_ADD:
                    r_page_add   <= i_cfg_wdata;
                dmtlb_pkg::CFG_HIT_COST:
                    r_hit_cost   <= i_cfg_wdata[dmtlb_pkg::COST_W-1:0];
                dmtlb_pkg::CFG_MISS_COST:
                    r_miss_cost  <= i_cfg_wdata[dmtlb_pkg::COST_W-1:0];
                default: ;
            endcase
        end
    end

    // Page split at accept; shift clamped so the page number fits the tag
    logic [dmtlb_pkg::SHIFT_W-1:0] eff_shift;
    logic [dmtlb_pkg::VA_W-1:0]    va_shifted;
    logic [dmtlb_pkg::VA_W-1:0]    r_va;
    logic [dmtlb_pkg::SHIFT_W-1:0] r_sh;
    logic [dmtlb_pkg::VPN_W-1:0]   r_vpn;

    always_comb begin
        eff_shift = r_page_shift;
        if (r_page_shift == dmtlb_pkg::SHIFT_ILL_LO) begin
            eff_shift = dmtlb_pkg::SHIFT_MIN;
        end else if (r_page_shift == dmtlb_pkg::SHIFT_ILL_HI) begin
            eff_shift = dmtlb_pkg::SHIFT_MAX;
        end
    end

    assign va_shifted = i_s_tdata >> eff_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_va  <= i_s_tdata;
            r_sh  <= eff_shift;
            r_vpn <= va_shifted[dmtlb_pkg::VPN_W-1:0];
        end
    end

    // Table index: low page bits, or a remainder worked out MOD_BITS bits a cycle
    logic [IDX_W-1:0] idx;

    generate
        if (POW2) begin : g_idx_pow2
            assign idx             = r_vpn[IDX_W-1:0] & IDX_LAST;
            assign o_stat.mod_done = 1'b1;
        end else begin : g_idx_mod
            localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(NUM_ENTRIES);
            logic [dmtlb_pkg::VA_W-1:0]      r_mod_sh;
            logic [IDX_W-1:0]                r_rem;
            logic [dmtlb_pkg::MOD_CNT_W-1:0] r_mod_cnt;
            logic [IDX_W-1:0]                n_rem;
            logic [dmtlb_pkg::MOD_BITS-1:0]  chunk;
            logic [IDX_W:0]                  acc;

            assign chunk = r_mod_sh[dmtlb_pkg::VA_W-1 -: dmtlb_pkg::MOD_BITS];

            always_comb begin
                n_rem = r_rem;
                acc   = '0;
                for (int b = dmtlb_pkg::MOD_BITS - 1; b >= 0; b--) begin
                    acc = {n_rem, chunk[b]};
                    if (acc >= N_EXT) begin
                        acc = acc - N_EXT;
                    end
                    n_rem = acc[IDX_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.accept) begin
                    r_mod_sh  <= {1'b0, va_shifted[dmtlb_pkg::VPN_W-1:0]};
                    r_rem     <= '0;
                    r_mod_cnt <= '0;
                end else if (i_cmd.mod_step) begin
                    r_mod_sh  <= r_mod_sh << dmtlb_pkg::MOD_BITS;
                    r_rem     <= n_rem;
                    r_mod_cnt <= r_mod_cnt + 1'b1;
                end
            end

            assign idx = r_rem;
            assign o_stat.mod_done =
                (r_mod_cnt == dmtlb_pkg::MOD_CNT_W'(dmtlb_pkg::MOD_STEPS));
        end
    endgenerate

    // Clearing pass over the entry table after reset
    logic [IDX_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_stat.clr_done = i_cmd.clr_step && (r_clr_cnt == IDX_LAST);

    // Entry table and lookup
    logic [dmtlb_pkg::ENTRY_W-1:0] rd_entry;
    logic [dmtlb_pkg::ENTRY_W-1:0] wr_entry;
    logic [IDX_W-1:0]              waddr;
    logic                          we;
    logic                          rd_valid;
    logic [dmtlb_pkg::VPN_W-1:0]   rd_tag;
    logic [dmtlb_pkg::FRAME_W-1:0] rd_frame;
    logic [dmtlb_pkg::FRAME_W-1:0] new_frame;
    logic                          hit;

    assign rd_valid  = rd_entry[0];
    assign rd_tag    = rd_entry[dmtlb_pkg::VPN_W:1];
    assign rd_frame  = rd_entry[dmtlb_pkg::ENTRY_W-1 -: dmtlb_pkg::FRAME_W];
    assign hit       = rd_valid && (rd_tag == r_vpn);
    assign new_frame = {1'b0, r_vpn} + r_page_add;

    assign we       = i_cmd.clr_step || (i_cmd.lookup && !hit);
    assign waddr    = i_cmd.clr_step ? r_clr_cnt : idx;
    assign wr_entry = i_cmd.clr_step ? '0 : {new_frame, r_vpn, 1'b1};

    dmtlb_ram #(
        .WIDTH (dmtlb_pkg::ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (idx),
        .o_rdata (rd_entry)
    );

    logic                          r_hit;
    logic [dmtlb_pkg::FRAME_W-1:0] r_frame;
    logic [dmtlb_pkg::CNT_W-1:0]   r_hits;
    logic [dmtlb_pkg::CNT_W-1:0]   r_misses;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit   <= hit;
            r_frame <= hit ? rd_frame : new_frame;
        end
    end

    // Saturating hit and miss counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cmd.lookup) begin
            if (hit) begin
                if (r_hits != '1) r_hits <= r_hits + 1'b1;
            end else begin
                if (r_misses != '1) r_misses <= r_misses + 1'b1;
            end
        end
    end

    // Result register
    logic [dmtlb_pkg::VA_W-1:0]   off_mask;
    logic [dmtlb_pkg::VA_W-1:0]   r_o_phys;
    logic                         r_o_hit;
    logic [dmtlb_pkg::COST_W-1:0] r_o_cost;
    logic [dmtlb_pkg::CNT_W-1:0]  r_o_hits;
    logic [dmtlb_pkg::CNT_W-1:0]  r_o_misses;

    assign off_mask = (dmtlb_pkg::VA_W'(1) << r_sh) - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_phys   <= (r_frame << r_sh) | (r_va & off_mask);
            r_o_hit    <= r_hit;
            r_o_cost   <= r_hit ? r_hit_cost : r_miss_cost;
            r_o_hits   <= r_hits;
            r_o_misses <= r_misses;
        end
    end

    assign o_m_tdata = {{PAD_W{1'b0}}, r_o_misses, r_o_hits, r_o_cost, r_o_hit, r_o_phys};
endmodule

// ===== sv/direct_mapped_tlb_translate_core.sv =====
// Direct-mapped TLB translate core: top level joining controller and datapath.
// The controller steps each address through index, table read, compare-refill and
// result register; when NUM_ENTRIES is not a power of two the index step runs a
// remainder unit that takes 8 address bits per cycle. A new address is taken only
// after the previous result has been loaded into the output register.
// Reset (synchronous, active low) clears counters and runs a clearing pass over the
// table; no input transfer is taken until it ends.
module direct_mapped_tlb_translate_core #(
    parameter int NUM_ENTRIES = dmtlb_pkg::NUM_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [dmtlb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dmtlb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [dmtlb_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // virt_addr[63:0]
    // Output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // phys_addr[63:0], was_hit[64], cost[80:65], total_hits[112:81],
    // total_misses[144:113], zero pad[151:145]
    output logic [dmtlb_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    dmtlb_pkg::t_dp_cmd  cmd;
    dmtlb_pkg::t_dp_stat stat;

    dmtlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    dmtlb_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the direct-mapped TLB translate core: directed table, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmtlb_pkg::*;

    localparam int N_ENT       = NUM_ENTRIES_DEF;
    localparam int N_PHASE     = 8;
    localparam int PHASE_ITEMS = 170;
    localparam int POOL_N      = 6;
    localparam int HOLD_CYC    = 300;
    localparam int SETTLE      = 16;
    localparam int LIMIT       = 200000;
    localparam int MAX_REPORTS = 40;
    localparam int DIR_N       = 25;

    // Result fields, MSB first so the struct lines up with o_m_tdata[144:0]
    typedef struct packed {
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   hits;
        logic [COST_W-1:0]  cost;
        logic               hit;
        logic [FRAME_W-1:0] phys;
    } t_xlat;

    typedef struct packed {
        logic                 is_wr;
        logic [CFG_IDX_W-1:0] idx;
        logic [VA_W-1:0]      val;    // register value or virtual address
        logic                 typed;  // expectation given in the row
        t_xlat                exp;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;    // virt_addr[63:0]
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // phys_addr[63:0], was_hit[64], cost[80:65], total_hits[112:81],
    // total_misses[144:113], zero pad[151:145]
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    direct_mapped_tlb_translate_core #(.NUM_ENTRIES(N_ENT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Translation model state
    logic [SHIFT_W-1:0] reg_shift;
    logic [FRAME_W-1:0] reg_add;
    logic [COST_W-1:0]  reg_hit_cost;
    logic [COST_W-1:0]  reg_miss_cost;
    logic [VPN_W-1:0]   tlb_tag   [N_ENT];
    logic [FRAME_W-1:0] tlb_frame [N_ENT];
    logic               tlb_vld   [N_ENT];
    logic [CNT_W-1:0]   cnt_hit;
    logic [CNT_W-1:0]   cnt_miss;

    t_xlat       xlat_q [$];
    bit          use_typed;
    t_xlat       typed_exp;
    int          err_cnt;
    int          n_sent;
    int          n_results;
    int          n_hits_seen;
    int          n_settings;
    int          cyc;
    int          src_idle_pct;
    int          snk_stall_pct;
    bit          hold_req;
    bit          hold_done;
    int unsigned cur_sh;
    logic [63:0] page_pool [POOL_N];

    function automatic t_xlat translate_va(input logic [VA_W-1:0] va);
        int unsigned      sh;
        int unsigned      slot;
        logic [VPN_W-1:0] vpn;
        logic             is_hit;
        t_xlat            r;
        sh = reg_shift;
        if (sh < SHIFT_MIN) sh = SHIFT_MIN;
        if (sh > SHIFT_MAX) sh = SHIFT_MAX;
        vpn = VPN_W'(va >> sh);
        slot = vpn % N_ENT;
        is_hit = tlb_vld[slot] && (tlb_tag[slot] == vpn);
        if (is_hit) begin
            if (cnt_hit != '1) cnt_hit = cnt_hit + 1'b1;
        end else begin
            if (cnt_miss != '1) cnt_miss = cnt_miss + 1'b1;
            tlb_tag[slot]   = vpn;
            tlb_frame[slot] = {1'b0, vpn} + reg_add;
            tlb_vld[slot]   = 1'b1;
        end
        r.phys   = (tlb_frame[slot] << sh) | (va & ((64'd1 << sh) - 64'd1));
        r.hit    = is_hit;
        r.cost   = is_hit ? reg_hit_cost : reg_miss_cost;
        r.hits   = cnt_hit;
        r.misses = cnt_miss;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc, xlat_q.size());
            $display("direct_mapped_tlb_translate_core: mismatch");
            $finish;
        end
    end

    // Predicts on each input transfer, checks each output transfer, tracks register writes
    always @(posedge i_clk) begin : scoreboard
        t_xlat got;
        t_xlat want;
        t_xlat pred;
        if (!i_rst_n) begin
            reg_shift     = SHIFT_RST;
            reg_add       = PAGE_ADD_RST;
            reg_hit_cost  = HIT_COST_RST;
            reg_miss_cost = MISS_COST_RST;
            cnt_hit       = '0;
            cnt_miss      = '0;
            for (int i = 0; i < N_ENT; i++) tlb_vld[i] = 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_xlat'(o_m_tdata[$bits(t_xlat)-1:0]);
                n_results++;
                if (got.hit === 1'b1) n_hits_seen++;
                if (xlat_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: result %h with nothing expected", $time, got);
                end else begin
                    want = xlat_q.pop_front();
                    check_field("phys_addr", want.phys, got.phys);
                    check_field("was_hit", want.hit, got.hit);
                    check_field("cost", want.cost, got.cost);
                    check_field("total_hits", want.hits, got.hits);
                    check_field("total_misses", want.misses, got.misses);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                pred = translate_va(i_s_tdata);
                xlat_q.push_back(use_typed ? typed_exp : pred);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PAGE_SHIFT: reg_shift     = i_cfg_wdata[SHIFT_W-1:0];
                    CFG_PAGE_ADD:   reg_add       = i_cfg_wdata;
                    CFG_HIT_COST:   reg_hit_cost  = i_cfg_wdata[COST_W-1:0];
                    CFG_MISS_COST:  reg_miss_cost = i_cfg_wdata[COST_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request
    initial begin : sink
        int hold_left;
        hold_left  = 0;
        hold_done  = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYC;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
            end
        end
    end

    task automatic send_va(input logic [VA_W-1:0] va, input bit typed = 1'b0,
                           input t_xlat exp = '0);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        use_typed  = typed;
        typed_exp  = exp;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= va;
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (xlat_q.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_dir_row dir_va(input logic [63:0] va);
        t_dir_row r;
        r = '0;
        r.val = va;
        return r;
    endfunction

    function automatic t_dir_row dir_wr(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        t_dir_row r;
        r = '0;
        r.is_wr = 1'b1;
        r.idx   = idx;
        r.val   = val;
        return r;
    endfunction

    function automatic t_dir_row dir_chk(input logic [63:0] va, input logic [63:0] phys,
                                         input logic hit, input logic [COST_W-1:0] cost,
                                         input logic [CNT_W-1:0] hits,
                                         input logic [CNT_W-1:0] misses);
        t_dir_row r;
        r = dir_va(va);
        r.typed      = 1'b1;
        r.exp.phys   = phys;
        r.exp.hit    = hit;
        r.exp.cost   = cost;
        r.exp.hits   = hits;
        r.exp.misses = misses;
        return r;
    endfunction

    // Mostly pages from a small working set so entries get reused and evicted
    function automatic logic [63:0] rand_va();
        logic [63:0] pg;
        logic [63:0] off;
        int unsigned r;
        r   = $urandom_range(99, 0);
        pg  = page_pool[$urandom_range(POOL_N - 1, 0)];
        off = {$urandom, $urandom};
        if (r < 15) begin
            pg = pg + N_ENT;                         // same slot, other tag
        end else if (r < 25) begin
            return {$urandom, $urandom};
        end else if (r < 30) begin
            off = $urandom_range(1, 0) ? '1 : '0;
        end
        return (pg << cur_sh) | (off & ((64'd1 << cur_sh) - 64'd1));
    endfunction

    initial begin : stim
        t_dir_row           dir_tab [DIR_N];
        logic [SHIFT_W-1:0] shift_v;
        logic [63:0]        add_v;
        logic [COST_W-1:0]  hc_v;
        logic [COST_W-1:0]  mc_v;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        use_typed     = 1'b0;
        typed_exp     = '0;
        err_cnt       = 0;
        n_sent        = 0;
        n_results     = 0;
        n_hits_seen   = 0;
        n_settings    = 1;
        cyc           = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b0;

        // Rows after reset use the reset register values: 4 KiB pages, add 4096
        dir_tab = '{
            dir_chk(64'h0, 64'h0000_0000_0100_0000, 1'b0, MISS_COST_RST, 32'd0, 32'd1),
            dir_chk(64'hFFF, 64'h0000_0000_0100_0FFF, 1'b1, HIT_COST_RST, 32'd1, 32'd1),
            dir_chk('1, 64'h0000_0000_00FF_FFFF, 1'b0, MISS_COST_RST, 32'd1, 32'd2),
            dir_chk('1, 64'h0000_0000_00FF_FFFF, 1'b1, HIT_COST_RST, 32'd2, 32'd2),
            dir_chk(64'h4000, 64'h0000_0000_0100_4000, 1'b0, MISS_COST_RST, 32'd2, 32'd3),
            dir_chk(64'h0, 64'h0000_0000_0100_0000, 1'b0, MISS_COST_RST, 32'd2, 32'd4),
            dir_chk(64'h8000_0000_0000_0000, 64'h8000_0000_0100_0000, 1'b0, MISS_COST_RST,
                    32'd2, 32'd5),
            // smallest page, wrapping add, extreme costs; old entries stay valid
            dir_wr(CFG_PAGE_SHIFT, 64'(SHIFT_MIN)),
            dir_wr(CFG_PAGE_ADD, '1),
            dir_wr(CFG_HIT_COST, 64'hFFFF),
            dir_wr(CFG_MISS_COST, 64'h0),
            dir_va(64'h0),
            dir_va(64'h1),
            dir_va('1),
            dir_va(64'h8000_0000_0000_0000),
            dir_va(64'h3),
            // shift below range acts as the minimum
            dir_wr(CFG_PAGE_SHIFT, 64'(SHIFT_ILL_LO)),
            dir_va(64'h5),
            dir_va(64'h4),
            dir_wr(CFG_PAGE_SHIFT, 64'(SHIFT_MAX)),
            dir_va('1),
            dir_va(64'hC000_0000_0000_0001),
            // shift above range acts as the maximum
            dir_wr(CFG_PAGE_SHIFT, 64'(SHIFT_ILL_HI)),
            dir_va('1),
            dir_va(64'h4000_0000_0000_0000)
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (dir_tab[i].is_wr) begin
                wait_idle(SETTLE);
                write_reg(dir_tab[i].idx, dir_tab[i].val);
                n_settings++;
            end else begin
                send_va(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].exp);
            end
        end

        for (int ph = 0; ph < N_PHASE; ph++) begin
            wait_idle(SETTLE);
            shift_v = $urandom_range(63, 0);
            add_v   = {$urandom, $urandom};
            hc_v    = $urandom_range(65535, 0);
            mc_v    = $urandom_range(65535, 0);
            case (ph)
                0: begin
                    shift_v = SHIFT_MIN; add_v = '0; hc_v = '0; mc_v = '1;
                end
                1: begin
                    shift_v = SHIFT_MAX; add_v = '1; hc_v = '1; mc_v = '0;
                end
                2: begin
                    shift_v = SHIFT_ILL_LO; add_v = PAGE_ADD_RST;
                    hc_v = HIT_COST_RST; mc_v = MISS_COST_RST;
                end
                3: shift_v = SHIFT_ILL_HI;
                4: shift_v = SHIFT_RST;
                default: ;
            endcase
            write_reg(CFG_PAGE_SHIFT, 64'(shift_v));
            write_reg(CFG_PAGE_ADD, add_v);
            write_reg(CFG_HIT_COST, 64'(hc_v));
            write_reg(CFG_MISS_COST, 64'(mc_v));
            n_settings++;

            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 34; snk_stall_pct = 34; end
            endcase

            cur_sh = (shift_v < SHIFT_MIN) ? SHIFT_MIN :
                     (shift_v > SHIFT_MAX) ? SHIFT_MAX : shift_v;
            for (int p = 0; p < POOL_N; p++) begin
                if (p[0])
                    page_pool[p] = page_pool[p-1] + N_ENT * $urandom_range(3, 1);
                else
                    page_pool[p] = {$urandom, $urandom} >> cur_sh;
            end

            // sender keeps offering while the output is held off: pipeline backs up
            if (ph == 0) hold_req = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 5 && k == PHASE_ITEMS / 2) wait_idle(0);
                send_va(rand_va());
            end
        end

        wait_idle(SETTLE);
        $display("translated %0d addresses (%0d hits) under %0d register settings,",
                 n_sent, n_hits_seen, n_settings);
        $display("with page shifts at both clamps and sender/receiver throttling");
        if (err_cnt == 0) begin
            $display("direct_mapped_tlb_translate_core: match");
        end else begin
            $display("direct_mapped_tlb_translate_core: mismatch");
        end
        $finish;
    end

endmodule
